FILE: design/pqt_pkg.sv
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared types and constants for the pending query table: request and result
// layouts, command and status codes, the table entry and the controller
// interface.
// ----------------------------------------------------------------------------
package pqt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Command codes
  localparam logic [2:0] CMD_SEND     = 3'd0;
  localparam logic [2:0] CMD_RESPONSE = 3'd1;
  localparam logic [2:0] CMD_EXPIRY   = 3'd2;
  localparam logic [2:0] CMD_PRUNE    = 3'd3;
  localparam logic [2:0] CMD_CANCEL   = 3'd4;
  localparam logic [2:0] CMD_LOOKUP   = 3'd5;

  // Entry status codes
  localparam logic [1:0] STS_WAITING  = 2'd0;
  localparam logic [1:0] STS_ANSWERED = 2'd1;
  localparam logic [1:0] STS_EXPIRED  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_BAD_INDEX = 2'd2;

  // Request payload
  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] query_id;
    logic [31:0]        now_ticks;
    logic [3:0]         entry_index;
  } pqt_in_t;

  // Result payload
  typedef struct packed {
    logic [1:0] error_code;
    logic [4:0] match_count;
    logic       any_expired;
    logic       table_changed;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] entries_used;
  } pqt_out_t;

  // One table entry
  typedef struct packed {
    logic [31:0] slot_id;
    logic [31:0] slot_time;
    logic [1:0]  slot_status;
    logic        slot_answered;
  } pqt_entry_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pqt_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } pqt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } pqt_stat_t;

endpackage

FILE: design/pqt_ctrl.sv
// ----------------------------------------------------------------------------
// pqt_ctrl
// Sequencer for the pending query table: takes a request, runs one scan of
// the used entries through the datapath, then commits and reports.
// ----------------------------------------------------------------------------
module pqt_ctrl
  import pqt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pqt_stat_t stat,
  output pqt_cmd_t  cmd
);

  pqt_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/pqt_dp.sv
// ----------------------------------------------------------------------------
// pqt_dp
// Datapath of the pending query table: entry memory, scan counters, result
// accumulators, entry count, timeout register and the result register.
// ----------------------------------------------------------------------------
module pqt_dp
  import pqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pqt_in_t     in_req,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  pqt_cmd_t    cmd,
  output pqt_stat_t   stat,
  output logic        out_valid,
  output pqt_out_t    out_res
);

  // Entry memory, one write and one registered read per cycle
  pqt_entry_t mem [TABLE_DEPTH];
  pqt_entry_t rd_q_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pqt_entry_t       wr_data;
  logic [IDX_W-1:0] rd_addr;

  // Control state
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [31:0]      timeout_r;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] wr_cnt_r, wr_cnt_nxt;
  logic             pv_r, pv_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state
  pqt_in_t          req_r, req_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [4:0]       match_r, match_nxt;
  logic             exp_r, exp_nxt;
  logic             found_r, found_nxt;
  logic [3:0]       fidx_r, fidx_nxt;
  pqt_out_t         out_r, out_nxt;

  // Per-entry decode
  logic        id_hit;
  logic [31:0] age;
  logic        send_ok;
  logic        cancel_ok;

  assign rd_addr   = rd_cnt_r[IDX_W-1:0];
  assign id_hit    = (rd_q_r.slot_id == $unsigned(req_r.query_id));
  assign age       = req_r.now_ticks - rd_q_r.slot_time;
  assign send_ok   = (used_r < CNT_W'(TABLE_DEPTH));
  assign cancel_ok = (CNT_W'(req_r.entry_index) < used_r);

  assign stat.scan_done = (rd_cnt_r >= used_r) && !pv_r;
  assign out_valid      = out_valid_r;
  assign out_res        = out_r;

  // Memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      timeout_r   <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    pidx_r  <= pidx_nxt;
    match_r <= match_nxt;
    exp_r   <= exp_nxt;
    found_r <= found_nxt;
    fidx_r  <= fidx_nxt;
    out_r   <= out_nxt;
  end

  // Scan, update and result logic
  always_comb begin
    used_nxt      = used_r;
    rd_cnt_nxt    = rd_cnt_r;
    wr_cnt_nxt    = wr_cnt_r;
    pv_nxt        = pv_r;
    out_valid_nxt = 1'b0;
    req_nxt       = req_r;
    pidx_nxt      = pidx_r;
    match_nxt     = match_r;
    exp_nxt       = exp_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = pidx_r;
    wr_data       = rd_q_r;

    // Capture a new request
    if (cmd.load) begin
      req_nxt    = in_req;
      rd_cnt_nxt = '0;
      wr_cnt_nxt = '0;
      pv_nxt     = 1'b0;
      match_nxt  = '0;
      exp_nxt    = 1'b0;
      found_nxt  = 1'b0;
      fidx_nxt   = '0;
    end

    // Scan: issue the next read, act on the entry read last cycle
    if (cmd.scan) begin
      pv_nxt = (rd_cnt_r < used_r);
      if (rd_cnt_r < used_r) begin
        pidx_nxt   = rd_cnt_r[IDX_W-1:0];
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      if (pv_r) begin
        case (req_r.command)
          CMD_RESPONSE: begin
            if (id_hit) begin
              wr_en                 = 1'b1;
              wr_data.slot_status   = STS_ANSWERED;
              wr_data.slot_answered = 1'b1;
              match_nxt             = match_r + 1'b1;
            end
          end
          CMD_EXPIRY: begin
            if ((timeout_r != '0) && (rd_q_r.slot_status == STS_WAITING)
                && (age > timeout_r)) begin
              wr_en               = 1'b1;
              wr_data.slot_status = STS_EXPIRED;
              exp_nxt             = 1'b1;
            end
          end
          CMD_PRUNE: begin
            // compact waiting entries toward the front
            if (rd_q_r.slot_status == STS_WAITING) begin
              wr_en      = 1'b1;
              wr_addr    = wr_cnt_r[IDX_W-1:0];
              wr_cnt_nxt = wr_cnt_r + 1'b1;
            end
          end
          CMD_CANCEL: begin
            // shift entries behind the removed one down by one
            if (cancel_ok && (CNT_W'(pidx_r) > CNT_W'(req_r.entry_index))) begin
              wr_en   = 1'b1;
              wr_addr = pidx_r - 1'b1;
            end
          end
          CMD_LOOKUP: begin
            if (!found_r && rd_q_r.slot_answered && id_hit) begin
              found_nxt = 1'b1;
              fidx_nxt  = 4'(pidx_r);
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Commit the new entry of a send and count changes, and load the result register
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      case (req_r.command)
        CMD_SEND: begin
          if (send_ok) begin
            wr_en                 = 1'b1;
            wr_addr               = used_r[IDX_W-1:0];
            wr_data.slot_id       = $unsigned(req_r.query_id);
            wr_data.slot_time     = req_r.now_ticks;
            wr_data.slot_status   = STS_WAITING;
            wr_data.slot_answered = 1'b0;
            used_nxt              = used_r + 1'b1;
          end else begin
            out_nxt.error_code = ERR_FULL;
          end
        end
        CMD_RESPONSE: begin
          out_nxt.match_count = match_r;
        end
        CMD_EXPIRY: begin
          out_nxt.any_expired = exp_r;
        end
        CMD_PRUNE: begin
          out_nxt.table_changed = (wr_cnt_r != used_r);
          used_nxt              = wr_cnt_r;
        end
        CMD_CANCEL: begin
          if (cancel_ok) begin
            used_nxt = used_r - 1'b1;
          end else begin
            out_nxt.error_code = ERR_BAD_INDEX;
          end
        end
        CMD_LOOKUP: begin
          out_nxt.found       = found_r;
          out_nxt.found_index = fidx_r;
        end
        default: begin
        end
      endcase
      out_nxt.entries_used = 5'(used_nxt);
    end
  end

  // Entry count never exceeds the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Compaction write pointer never overtakes the read pointer
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt_r <= rd_cnt_r)
    else $error("prune write pointer ahead of read pointer");

  // A result strobe lasts one cycle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  // A found lookup points inside the table
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |-> (5'(out_r.found_index) < out_r.entries_used))
    else $error("lookup index beyond entry count");

endmodule

FILE: design/pending_query_table_with_timeout.sv
// ----------------------------------------------------------------------------
// pending_query_table_with_timeout
// Ordered table of outstanding queries: send, response, expiry check, prune,
// cancel and lookup, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request scans
// the used entries once through an entry memory with one read and one write
// port, one entry per cycle, so busy stays high through the scan and the
// commit. The result strobe out_valid is high for one cycle, the first cycle in
// which busy is low again. The receiver cannot stall: out_res is valid only
// while out_valid is high. A new request may be taken in the same cycle as
// that strobe. cfg_we/cfg_wdata write the timeout register; write it only
// while busy is low.
module pending_query_table_with_timeout
  import pqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pqt_in_t     in_req,
  output logic        out_valid,
  output pqt_out_t    out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  pqt_cmd_t  cmd;
  pqt_stat_t stat;

  // Sequencer
  pqt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table datapath
  pqt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

FILE: dv/pqt_checker.sv
// ----------------------------------------------------------------------------
// pqt_checker
// Watches the request, result and timeout register ports of the pending query
// table. It keeps its own copy of the table, works out the status for every
// accepted request and compares each result strobe against the oldest one.
// ----------------------------------------------------------------------------
module pqt_checker
  import pqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  pqt_in_t     in_req,
  input  logic        out_valid,
  input  pqt_out_t    out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          error_total,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow table, entry count and timeout register
  pqt_entry_t  slots [TABLE_DEPTH];
  int          used_q;
  logic [31:0] timeout_q;

  // Statuses of accepted requests not yet seen on the result port
  pqt_out_t    awaited_status [$];

  initial begin
    error_total = 0;
    pending_cnt = 0;
    used_q      = 0;
    timeout_q   = '0;
  end

  // Apply one request to the shadow table and return the status it reports
  function automatic pqt_out_t table_apply(pqt_in_t r);
    pqt_out_t    res;
    int          kept;
    logic [31:0] age;
    res = '0;
    case (r.command)
      CMD_SEND: begin
        if (used_q >= TABLE_DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          slots[used_q] = '{slot_id: r.query_id, slot_time: r.now_ticks,
                            slot_status: STS_WAITING, slot_answered: 1'b0};
          used_q++;
        end
      end
      CMD_RESPONSE: begin
        // every matching id is answered, expired ones too
        for (int i = 0; i < used_q; i++) begin
          if (slots[i].slot_id == r.query_id) begin
            slots[i].slot_answered = 1'b1;
            slots[i].slot_status   = STS_ANSWERED;
            res.match_count        = res.match_count + 5'd1;
          end
        end
      end
      CMD_EXPIRY: begin
        // age is taken mod 2^32; a zero timeout disables expiry
        if (timeout_q != 0) begin
          for (int i = 0; i < used_q; i++) begin
            age = r.now_ticks - slots[i].slot_time;
            if (slots[i].slot_status == STS_WAITING && age > timeout_q) begin
              slots[i].slot_status = STS_EXPIRED;
              res.any_expired      = 1'b1;
            end
          end
        end
      end
      CMD_PRUNE: begin
        kept = 0;
        for (int i = 0; i < used_q; i++) begin
          if (slots[i].slot_status == STS_WAITING) begin
            slots[kept] = slots[i];
            kept++;
          end
        end
        res.table_changed = (kept != used_q);
        used_q = kept;
      end
      CMD_CANCEL: begin
        if (r.entry_index >= used_q) begin
          res.error_code = ERR_BAD_INDEX;
        end else begin
          for (int i = r.entry_index; i + 1 < used_q; i++) slots[i] = slots[i + 1];
          used_q--;
        end
      end
      CMD_LOOKUP: begin
        for (int i = 0; i < used_q; i++) begin
          if (!res.found && slots[i].slot_answered &&
              slots[i].slot_id == r.query_id) begin
            res.found       = 1'b1;
            res.found_index = 4'(i);
          end
        end
      end
      default: ;
    endcase
    res.entries_used = 5'(used_q);
    return res;
  endfunction

  // Result compare, register shadow and request capture, all on the edge
  always @(posedge clk) begin
    pqt_out_t want;
    if (!rst_n) begin
      used_q    = 0;
      timeout_q = '0;
      awaited_status.delete();
    end else begin
      if (out_valid) begin
        if (awaited_status.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: result with no request outstanding: %p", $realtime, out_res);
        end else begin
          want = awaited_status.pop_front();
          if (out_res.error_code    !== want.error_code    ||
              out_res.match_count   !== want.match_count   ||
              out_res.any_expired   !== want.any_expired   ||
              out_res.table_changed !== want.table_changed ||
              out_res.found         !== want.found         ||
              out_res.found_index   !== want.found_index   ||
              out_res.entries_used  !== want.entries_used) begin
            error_total++;
            if (error_total <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected err=%0d match=%0d exp=%0d chg=%0d found=%0d idx=%0d used=%0d",
                       want.error_code, want.match_count, want.any_expired,
                       want.table_changed, want.found, want.found_index,
                       want.entries_used);
              $display("  actual   err=%0d match=%0d exp=%0d chg=%0d found=%0d idx=%0d used=%0d",
                       out_res.error_code, out_res.match_count, out_res.any_expired,
                       out_res.table_changed, out_res.found, out_res.found_index,
                       out_res.entries_used);
            end
          end
        end
      end
      if (cfg_we) timeout_q = cfg_wdata;
      if (start && !busy) awaited_status = {awaited_status, table_apply(in_req)};
    end
    pending_cnt = awaited_status.size();
  end

endmodule

FILE: dv/tb_pending_query_table_with_timeout.sv
// ----------------------------------------------------------------------------
// tb_pending_query_table_with_timeout
// Drives the pending query table with a short directed sequence and then with
// phases of random send/response/expiry/prune/cancel/lookup traffic over
// several timeout settings and idle patterns. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_pending_query_table_with_timeout
  import pqt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PHASES          = 8;
  localparam int         ITEMS_PER_PHASE = 240;
  localparam int         DRAIN_CYCLES    = 40;
  localparam int         LIMIT_CYCLES    = 600000;
  localparam logic [2:0] CMD_UNUSED_6    = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7    = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  pqt_in_t     in_req;
  logic        out_valid;
  pqt_out_t    out_res;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          error_total;
  int          pending_cnt;
  int          cycles = 0;

  // Random traffic shaping
  logic [31:0] id_pool [8];
  int          pool_size;
  logic [31:0] cur_time;
  int          time_step;
  int          send_pct;
  bit          quiet;
  logic [31:0] phase_timeout [PHASES] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd40, 32'd100,
                                         32'd7, 32'h8000_0000, 32'd25};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pending_query_table_with_timeout u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pqt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .error_total (error_total),
    .pending_cnt (pending_cnt)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic pqt_in_t make_req(logic [2:0] cmd, logic [31:0] id,
                                       logic [31:0] now, logic [3:0] idx);
    pqt_in_t r;
    r.command     = cmd;
    r.query_id    = id;
    r.now_ticks   = now;
    r.entry_index = idx;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none in quiet phases
  function automatic int idle_len();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Well-formed traffic on a small id pool with advancing time, plus noise
  function automatic pqt_in_t random_request();
    pqt_in_t r;
    int      roll;
    cur_time = cur_time + $urandom_range(0, time_step);
    r = make_req(CMD_SEND, id_pool[$urandom_range(0, pool_size - 1)], cur_time,
                 4'($urandom_range(0, 15)));
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      r.command   = 3'($urandom_range(0, 7));
      r.query_id  = $urandom;
      r.now_ticks = $urandom;
    end else if (roll >= 6 + send_pct) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
        r.command = CMD_RESPONSE;
        if ($urandom_range(0, 19) == 0) r.query_id = $urandom;
      end else if (roll < 48) begin
        r.command = CMD_EXPIRY;
      end else if (roll < 62) begin
        r.command = CMD_PRUNE;
      end else if (roll < 82) begin
        r.command = CMD_CANCEL;
        if ($urandom_range(0, 3) != 0) r.entry_index = 4'($urandom_range(0, 5));
      end else begin
        r.command = CMD_LOOKUP;
      end
    end
    return r;
  endfunction

  // Present one request at a falling edge and hold it until taken.
  // Called and returns at a falling edge.
  task automatic send_req(input pqt_in_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Timeout register write, only once the table is idle
  task automatic set_timeout(input logic [31:0] value);
    start <= 1'b0;
    while (pending_cnt != 0 || busy) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table corner cases and unknown commands
    send_req(make_req(CMD_LOOKUP, 32'd5, 32'd0, 4'd0));
    send_req(make_req(CMD_CANCEL, 32'd0, 32'd0, 4'd0));
    send_req(make_req(CMD_PRUNE, 32'd0, 32'd0, 4'd0));
    send_req(make_req(CMD_EXPIRY, 32'd0, 32'hFFFF_FFFF, 4'd0));
    send_req(make_req(CMD_UNUSED_6, 32'd1, 32'd1, 4'd1));
    send_req(make_req(CMD_UNUSED_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));

    // Extreme ids and times, duplicate id answered twice
    send_req(make_req(CMD_SEND, 32'h8000_0000, 32'hFFFF_FFF0, 4'd0));
    send_req(make_req(CMD_SEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    send_req(make_req(CMD_SEND, 32'hFFFF_FFFF, 32'd0, 4'd0));
    send_req(make_req(CMD_SEND, 32'h7FFF_FFFF, 32'd5, 4'd0));
    send_req(make_req(CMD_RESPONSE, 32'h7FFF_FFFF, 32'd0, 4'd0));
    send_req(make_req(CMD_LOOKUP, 32'h7FFF_FFFF, 32'd0, 4'd0));
    send_req(make_req(CMD_LOOKUP, 32'h8000_0000, 32'd0, 4'd0));
    send_req(make_req(CMD_CANCEL, 32'd0, 32'd0, 4'd15));

    // Expiry across the time wrap, response revives an expired entry, prune
    set_timeout(32'd10);
    send_req(make_req(CMD_EXPIRY, 32'd0, 32'd12, 4'd0));
    send_req(make_req(CMD_RESPONSE, 32'hFFFF_FFFF, 32'd0, 4'd0));
    send_req(make_req(CMD_PRUNE, 32'd0, 32'd0, 4'd0));

    // Age equal to the timeout does not expire, one tick more does
    send_req(make_req(CMD_SEND, 32'h0000_1234, 32'd100, 4'd0));
    send_req(make_req(CMD_SEND, 32'h0000_5678, 32'd105, 4'd0));
    send_req(make_req(CMD_SEND, 32'h0000_1234, 32'd110, 4'd0));
    send_req(make_req(CMD_EXPIRY, 32'd0, 32'd110, 4'd0));
    send_req(make_req(CMD_EXPIRY, 32'd0, 32'd111, 4'd0));

    // Cancel from the middle, then the last entry
    send_req(make_req(CMD_CANCEL, 32'd0, 32'd0, 4'd1));
    send_req(make_req(CMD_CANCEL, 32'd0, 32'd0, 4'd1));

    // Random phases over several timeout settings
    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) phase_timeout[p] = $urandom_range(20, 200);
      set_timeout(phase_timeout[p]);
      quiet     = (p % 3 == 2);
      send_pct  = (p % 2 == 1) ? 55 : 35;
      pool_size = $urandom_range(2, 8);
      for (int k = 0; k < 8; k++) id_pool[k] = $urandom;
      if (p % 2 == 0) begin
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7FFF_FFFF;
      end
      cur_time  = (p == 0) ? 32'hFFFF_FF00 : $urandom;
      time_step = (phase_timeout[p] != 0 && phase_timeout[p] < 1000) ?
                  phase_timeout[p] / 3 + 2 : 20;
      repeat (ITEMS_PER_PHASE) send_req(random_request());
    end

    // Drain
    start <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
